[rtl/hlfd_pkg.sv]
// shared types, codes and helpers of the heartbeat lru failover dispatcher
package hlfd_pkg;

  localparam int TIME_W = 48;
  localparam int REG_W  = 24;
  localparam int TAG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // event codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CONNECT = 3'd1;
  localparam logic [2:0] ACT_HBEAT   = 3'd2;
  localparam logic [2:0] ACT_REPLY   = 3'd3;
  localparam logic [2:0] ACT_REQUEST = 3'd4;

  // result codes
  localparam logic [2:0] KIND_HBEAT   = 3'd0;
  localparam logic [2:0] KIND_FORWARD = 3'd1;
  localparam logic [2:0] KIND_REPLY   = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_REJECT  = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HB_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TO  = 2'd1;

  localparam logic [REG_W-1:0] HB_PERIOD_RST = 24'd500000;
  localparam logic [REG_W-1:0] REPLY_TO_RST  = 24'd2000000;

  typedef struct packed {
    logic [2:0]        action;
    logic [2:0]        server_slot;
    logic [TAG_W-1:0]  request_tag;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       target_slot;
    logic [TAG_W-1:0] out_tag;
    logic             last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_BEAT,
    ST_EXPIRE,
    ST_FORWARD,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic event_go;
    logic beat;
    logic expire;
    logic forward;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic beat_due;
    logic beat_last;
    logic expire_done;
  } dp_stat_t;

  // time plus register value, saturating at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [REG_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-REG_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

[rtl/heartbeat_lru_failover_dispatcher.sv]
// top level of the heartbeat supervised lru request dispatcher
// Usage:
//   Input channel: present an event on in_item with start high; it is taken
//   at a clock edge where start is high and busy is low. busy stays high
//   until all results of that event have been issued.
//   Result channel: every result is on out_item for one cycle with
//   out_strobe high; the receiver must take it, there is no back-pressure.
//   The final result of an event has out_item.last set; an event may give
//   no result at all.
//   Configuration: cfg_valid with cfg_index and cfg_data writes a register
//   (0 heartbeat period, 1 reply timeout); cfg_ready is always high. Write
//   only while busy is low.
//   Timing: busy stays high through the event step, a heartbeat fan-out over
//   all slots when one is due, the expiry walk dropping expired servers one by
//   one (up to 8), the forward step and the flush step; no new event is taken
//   before then. A result waits for the next one or the flush; the final one
//   is on out_item in the first cycle with busy low.
//   Reset: synchronous, active low; no servers, no request, a beat due at
//   once, registers at their default values.
module heartbeat_lru_failover_dispatcher
  import hlfd_pkg::*;
#(
  parameter int SERVER_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  // sequencer
  hlfd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  hlfd_datapath #(
    .SERVER_SLOTS (SERVER_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_item    (in_item),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

[rtl/hlfd_ctrl.sv]
// sequencing state machine of the dispatcher
module hlfd_ctrl
  import hlfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (start) state_nxt = ST_EVENT;
      ST_EVENT:   state_nxt = stat.beat_due ? ST_BEAT : ST_EXPIRE;
      ST_BEAT:    if (stat.beat_last) state_nxt = ST_EXPIRE;
      ST_EXPIRE:  if (stat.expire_done) state_nxt = ST_FORWARD;
      ST_FORWARD: state_nxt = ST_FLUSH;
      ST_FLUSH:   state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EVENT:   cmd.event_go = 1'b1;
      ST_BEAT:    cmd.beat     = 1'b1;
      ST_EXPIRE:  cmd.expire   = 1'b1;
      ST_FORWARD: cmd.forward  = 1'b1;
      ST_FLUSH:   cmd.flush    = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

[rtl/hlfd_datapath.sv]
// server state, queues, deadlines and result staging of the dispatcher
module hlfd_datapath
  import hlfd_pkg::*;
#(
  parameter int SERVER_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output logic                 out_strobe,
  output out_item_t            out_item
);

  localparam int NS   = (SERVER_SLOTS < 8) ? SERVER_SLOTS : 8;
  localparam int IDXW = $clog2(NS);
  localparam int CNTW = $clog2(NS + 1);
  localparam logic [CNTW-1:0] NS_C = CNTW'(NS);

  // configuration
  logic [REG_W-1:0] hb_period_r, reply_to_r;

  // control state
  logic [NS-1:0]     conn_r, conn_nxt;
  logic [NS-1:0]     alive_r, alive_nxt;
  logic [CNTW-1:0]   lru_cnt_r, lru_cnt_nxt;
  logic [CNTW-1:0]   live_cnt_r, live_cnt_nxt;
  logic              busy_v_r, busy_v_nxt;
  logic [IDXW-1:0]   busy_slot_r, busy_slot_nxt;
  logic [TIME_W-1:0] ans_r, ans_nxt;
  logic [TIME_W-1:0] next_beat_r, next_beat_nxt;
  logic              pend_r, pend_nxt;
  logic [TAG_W-1:0]  ptag_r, ptag_nxt;
  logic [IDXW-1:0]   beat_cnt_r, beat_cnt_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic              ostb_r, ostb_nxt;

  // payload state
  in_item_t          item_r, item_nxt;
  logic [IDXW-1:0]   lru_r  [NS];
  logic [IDXW-1:0]   lru_nxt [NS];
  logic [IDXW-1:0]   live_r [NS];
  logic [IDXW-1:0]   live_nxt [NS];
  logic [TIME_W-1:0] dl_r   [NS];
  logic [TIME_W-1:0] dl_nxt [NS];
  out_item_t         hold_r, hold_nxt;
  out_item_t         oitem_r, oitem_nxt;

  // shared decode
  logic [TIME_W-1:0] now;
  logic              sok;
  logic [IDXW-1:0]   sidx;
  logic [IDXW-1:0]   head_live;
  logic              expire_hit;
  logic              emit_v;
  out_item_t         emit_item;

  assign now        = item_r.now_time;
  assign sok        = int'(item_r.server_slot) < SERVER_SLOTS;
  assign sidx       = item_r.server_slot[IDXW-1:0];
  assign head_live  = live_r[0];
  assign expire_hit = (live_cnt_r != '0) && (now >= dl_r[head_live]);

  assign stat.beat_due    = now >= next_beat_r;
  assign stat.beat_last   = int'(beat_cnt_r) == NS - 1;
  assign stat.expire_done = !expire_hit;

  // next state of everything
  always_comb begin
    logic            found;
    logic [IDXW-1:0] pos;
    logic [CNTW-1:0] cnt_tmp;
    logic            beff;
    logic [IDXW-1:0] lhead;

    found = 1'b0;
    pos = '0;
    cnt_tmp = '0;
    beff = 1'b0;
    lhead = lru_r[0];

    conn_nxt = conn_r;
    alive_nxt = alive_r;
    lru_cnt_nxt = lru_cnt_r;
    live_cnt_nxt = live_cnt_r;
    busy_v_nxt = busy_v_r;
    busy_slot_nxt = busy_slot_r;
    ans_nxt = ans_r;
    next_beat_nxt = next_beat_r;
    pend_nxt = pend_r;
    ptag_nxt = ptag_r;
    beat_cnt_nxt = beat_cnt_r;
    hold_v_nxt = hold_v_r;
    ostb_nxt = 1'b0;
    item_nxt = item_r;
    lru_nxt = lru_r;
    live_nxt = live_r;
    dl_nxt = dl_r;
    hold_nxt = hold_r;
    oitem_nxt = oitem_r;
    emit_v = 1'b0;
    emit_item = '0;

    if (cmd.load) begin
      item_nxt = in_item;
    end

    // event handling
    if (cmd.event_go) begin
      if (stat.beat_due) begin
        next_beat_nxt = sat_add(now, hb_period_r);
        beat_cnt_nxt = '0;
      end
      unique case (item_r.action)
        ACT_CONNECT: begin
          if (sok) begin
            conn_nxt[sidx] = 1'b1;
            emit_v = 1'b1;
            emit_item.kind = KIND_ACK;
            emit_item.target_slot = item_r.server_slot;
          end
        end
        ACT_HBEAT: begin
          if (sok && conn_r[sidx]) begin
            cnt_tmp = live_cnt_r;
            if (alive_r[sidx]) begin
              for (int i = 0; i < NS; i++) begin
                if (!found && CNTW'(i) < live_cnt_r && live_r[i] == sidx) begin
                  found = 1'b1;
                  pos = IDXW'(i);
                end
              end
              for (int i = 0; i < NS - 1; i++) begin
                if (found && i >= int'(pos)) live_nxt[i] = live_r[i+1];
              end
              if (found) cnt_tmp = live_cnt_r - 1'b1;
            end else begin
              if (lru_cnt_r < NS_C) begin
                lru_nxt[lru_cnt_r[IDXW-1:0]] = sidx;
                lru_cnt_nxt = lru_cnt_r + 1'b1;
              end
              alive_nxt[sidx] = 1'b1;
            end
            dl_nxt[sidx] = sat_add(now, hb_period_r);
            if (cnt_tmp < NS_C) begin
              live_nxt[cnt_tmp[IDXW-1:0]] = sidx;
              cnt_tmp = cnt_tmp + 1'b1;
            end
            live_cnt_nxt = cnt_tmp;
          end
        end
        ACT_REPLY: begin
          if (sok && conn_r[sidx] && busy_v_r && busy_slot_r == sidx) begin
            emit_v = 1'b1;
            emit_item.kind = KIND_REPLY;
            emit_item.target_slot = item_r.server_slot;
            emit_item.out_tag = ptag_r;
            pend_nxt = 1'b0;
            ptag_nxt = '0;
            busy_v_nxt = 1'b0;
          end
        end
        ACT_REQUEST: begin
          if (pend_r) begin
            emit_v = 1'b1;
            emit_item.kind = KIND_REJECT;
            emit_item.out_tag = item_r.request_tag;
          end else begin
            pend_nxt = 1'b1;
            ptag_nxt = item_r.request_tag;
          end
        end
        default: begin
        end
      endcase
    end

    // heartbeat fan-out, one slot a cycle
    if (cmd.beat) begin
      if (conn_r[beat_cnt_r]) begin
        emit_v = 1'b1;
        emit_item.kind = KIND_HBEAT;
        emit_item.target_slot = 3'(beat_cnt_r);
      end
      if (!stat.beat_last) beat_cnt_nxt = beat_cnt_r + 1'b1;
    end

    // expiry walk, one live head a cycle
    if (cmd.expire && expire_hit) begin
      for (int i = 0; i < NS - 1; i++) live_nxt[i] = live_r[i+1];
      live_cnt_nxt = live_cnt_r - 1'b1;
      alive_nxt[head_live] = 1'b0;
      for (int i = 0; i < NS; i++) begin
        if (!found && CNTW'(i) < lru_cnt_r && lru_r[i] == head_live) begin
          found = 1'b1;
          pos = IDXW'(i);
        end
      end
      for (int i = 0; i < NS - 1; i++) begin
        if (found && i >= int'(pos)) lru_nxt[i] = lru_r[i+1];
      end
      if (found) lru_cnt_nxt = lru_cnt_r - 1'b1;
    end

    // reply timeout and forward to least recently used server
    if (cmd.forward) begin
      beff = busy_v_r && !(now >= ans_r);
      busy_v_nxt = beff;
      if (pend_r && !beff && lru_cnt_r != '0) begin
        emit_v = 1'b1;
        emit_item.kind = KIND_FORWARD;
        emit_item.target_slot = 3'(lhead);
        emit_item.out_tag = ptag_r;
        busy_v_nxt = 1'b1;
        busy_slot_nxt = lhead;
        ans_nxt = sat_add(now, reply_to_r);
        for (int i = 0; i < NS - 1; i++) begin
          if (CNTW'(i + 1) < lru_cnt_r) lru_nxt[i] = lru_r[i+1];
        end
        lru_nxt[IDXW'(lru_cnt_r - 1'b1)] = lhead;
      end
    end

    // one result held back so the final one can be marked
    if (emit_v) begin
      if (hold_v_r) begin
        ostb_nxt = 1'b1;
        oitem_nxt = hold_r;
        oitem_nxt.last = 1'b0;
      end
      hold_nxt = emit_item;
      hold_v_nxt = 1'b1;
    end
    if (cmd.flush && hold_v_r) begin
      ostb_nxt = 1'b1;
      oitem_nxt = hold_r;
      oitem_nxt.last = 1'b1;
      hold_v_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_period_r <= HB_PERIOD_RST;
      reply_to_r  <= REPLY_TO_RST;
      conn_r      <= '0;
      alive_r     <= '0;
      lru_cnt_r   <= '0;
      live_cnt_r  <= '0;
      busy_v_r    <= 1'b0;
      busy_slot_r <= '0;
      ans_r       <= '0;
      next_beat_r <= '0;
      pend_r      <= 1'b0;
      ptag_r      <= '0;
      beat_cnt_r  <= '0;
      hold_v_r    <= 1'b0;
      ostb_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_HB_PERIOD) hb_period_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_REPLY_TO) reply_to_r <= cfg_data;
      conn_r      <= conn_nxt;
      alive_r     <= alive_nxt;
      lru_cnt_r   <= lru_cnt_nxt;
      live_cnt_r  <= live_cnt_nxt;
      busy_v_r    <= busy_v_nxt;
      busy_slot_r <= busy_slot_nxt;
      ans_r       <= ans_nxt;
      next_beat_r <= next_beat_nxt;
      pend_r      <= pend_nxt;
      ptag_r      <= ptag_nxt;
      beat_cnt_r  <= beat_cnt_nxt;
      hold_v_r    <= hold_v_nxt;
      ostb_r      <= ostb_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    lru_r   <= lru_nxt;
    live_r  <= live_nxt;
    dl_r    <= dl_nxt;
    hold_r  <= hold_nxt;
    oitem_r <= oitem_nxt;
  end

  assign out_strobe = ostb_r;
  assign out_item   = oitem_r;

endmodule

[tb/sv/hlfd_checker.sv]
// checker for the dispatcher: watches the ports, predicts results and compares them
module hlfd_checker
  import hlfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_item,
  input  logic                 out_strobe,
  input  out_item_t            out_item,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;

  // predicted dispatcher state
  logic [REG_W-1:0]  beat_period;
  logic [REG_W-1:0]  reply_window;
  logic [SLOTS-1:0]  conn_mask;
  logic [SLOTS-1:0]  live_mask;
  logic [TIME_W-1:0] live_until [SLOTS];
  logic [2:0]        lru_q[$];
  logic [2:0]        beat_q[$];
  logic              req_busy;
  logic [2:0]        req_slot;
  logic [TIME_W-1:0] reply_due;
  logic [TIME_W-1:0] beat_due;
  logic              req_held;
  logic [TAG_W-1:0]  held_tag;

  out_item_t due_results[$];

  assign outstanding = due_results.size();

  function automatic logic [TIME_W-1:0] clamp_sum(input logic [TIME_W-1:0] a,
                                                  input logic [REG_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-REG_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic void drop_slot(ref logic [2:0] q[$], input logic [2:0] s);
    logic [2:0] kept[$];
    foreach (q[i]) if (q[i] != s) kept.push_back(q[i]);
    q = kept;
  endfunction

  function automatic void add_slot(ref logic [2:0] q[$], input logic [2:0] s);
    if (q.size() < SLOTS) q.push_back(s);
  endfunction

  // work out every result one request causes
  function automatic void dispatch_predict(input in_item_t it);
    out_item_t r;
    out_item_t res[$];
    logic [2:0] s;
    logic [2:0] hd;
    s = it.server_slot;
    r = '0;
    // event part
    case (it.action)
      ACT_CONNECT: begin
        conn_mask[s] = 1'b1;
        r.kind = KIND_ACK; r.target_slot = s; r.out_tag = '0;
        res.push_back(r);
      end
      ACT_HBEAT: begin
        if (conn_mask[s]) begin
          if (live_mask[s]) drop_slot(beat_q, s);
          else begin
            add_slot(lru_q, s);
            live_mask[s] = 1'b1;
          end
          live_until[s] = clamp_sum(it.now_time, beat_period);
          add_slot(beat_q, s);
        end
      end
      ACT_REPLY: begin
        if (conn_mask[s] && req_busy && req_slot == s) begin
          r.kind = KIND_REPLY; r.target_slot = s; r.out_tag = held_tag;
          res.push_back(r);
          req_held = 1'b0;
          held_tag = '0;
          req_busy = 1'b0;
        end
      end
      ACT_REQUEST: begin
        if (req_held) begin
          r.kind = KIND_REJECT; r.target_slot = '0; r.out_tag = it.request_tag;
          res.push_back(r);
        end else begin
          req_held = 1'b1;
          held_tag = it.request_tag;
        end
      end
      default: ;
    endcase
    // heartbeat fan-out
    if (it.now_time >= beat_due) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (conn_mask[i]) begin
          r.kind = KIND_HBEAT; r.target_slot = i[2:0]; r.out_tag = '0;
          res.push_back(r);
        end
      end
      beat_due = clamp_sum(it.now_time, beat_period);
    end
    // expiry walk
    while (beat_q.size() > 0) begin
      hd = beat_q[0];
      if (it.now_time < live_until[hd]) break;
      drop_slot(beat_q, hd);
      drop_slot(lru_q, hd);
      live_mask[hd] = 1'b0;
    end
    // overdue reply
    if (req_busy && it.now_time >= reply_due) req_busy = 1'b0;
    // forward to least recently used server
    if (req_held && !req_busy && lru_q.size() > 0) begin
      hd = lru_q[0];
      r.kind = KIND_FORWARD; r.target_slot = hd; r.out_tag = held_tag;
      res.push_back(r);
      req_busy = 1'b1;
      req_slot = hd;
      reply_due = clamp_sum(it.now_time, reply_window);
      drop_slot(lru_q, hd);
      add_slot(lru_q, hd);
    end
    foreach (res[i]) begin
      res[i].last = (i == res.size() - 1);
      due_results.push_back(res[i]);
    end
  endfunction

  // sample at the falling edge, where everything the next rising edge takes is settled
  always @(negedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      beat_period  = HB_PERIOD_RST;
      reply_window = REPLY_TO_RST;
      conn_mask = '0;
      live_mask = '0;
      foreach (live_until[i]) live_until[i] = '0;
      lru_q.delete();
      beat_q.delete();
      req_busy = 1'b0;
      req_slot = '0;
      reply_due = '0;
      beat_due = '0;
      req_held = 1'b0;
      held_tag = '0;
      due_results.delete();
      fail_count = 0;
    end else begin
      // result check
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          $display("%t unexpected result: expected none, actual %h", $realtime, out_item);
          fail_count++;
        end else begin
          exp_r = due_results.pop_front();
          if (out_item.kind !== exp_r.kind || out_item.target_slot !== exp_r.target_slot ||
              out_item.out_tag !== exp_r.out_tag || out_item.last !== exp_r.last) begin
            $display("%t result mismatch: expected kind %0d slot %0d tag %h last %0d, ",
                     $realtime, exp_r.kind, exp_r.target_slot, exp_r.out_tag, exp_r.last,
                     "actual kind %0d slot %0d tag %h last %0d",
                     out_item.kind, out_item.target_slot, out_item.out_tag, out_item.last);
            fail_count++;
          end
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HB_PERIOD) beat_period = cfg_data;
        else if (cfg_index == CFG_REPLY_TO) reply_window = cfg_data;
      end
      // accepted request
      if (start && !busy) dispatch_predict(in_item);
    end
  end

endmodule

[tb/sv/tb_heartbeat_lru_failover_dispatcher.sv]
// testbench top: drives events and register writes into the dispatcher and gives the verdict
module tb_heartbeat_lru_failover_dispatcher;
  import hlfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   outstanding;

  logic [TIME_W-1:0] now_us;
  logic [REG_W-1:0]  period_now;
  logic [2:0]        fwd_slot;
  int                idle_pct;

  heartbeat_lru_failover_dispatcher dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hlfd_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // remember which server got the last forward so replies can hit it
  always @(negedge clk) begin
    if (!rst_n) fwd_slot <= '0;
    else if (out_strobe && out_item.kind == KIND_FORWARD) fwd_slot <= out_item.target_slot;
  end

  // one event request, held until taken
  task automatic send_event(input logic [2:0] act, input logic [2:0] slot,
                            input logic [TAG_W-1:0] tag);
    logic taken;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{action: act, server_slot: slot, request_tag: tag, now_time: now_us};
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  // wait until the block has drained, then let its walk finish
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    if (idx == CFG_HB_PERIOD) period_now = val;
    @(posedge clk);
  endtask

  // random event with a mostly well-behaved time step
  task automatic random_event();
    int pick;
    logic [2:0] act;
    logic [2:0] slot;
    int span;
    span = (period_now < 8) ? 8 : (period_now > 4000000 ? 4000000 : period_now);
    pick = $urandom_range(99);
    if (pick < 8) now_us = now_us + span * 2;
    else if (pick < 90) now_us = now_us + $urandom_range(0, span * 3 / 4);
    slot = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 10) act = ACT_CONNECT;
    else if (pick < 45) act = ACT_HBEAT;
    else if (pick < 65) begin
      act = ACT_REPLY;
      if ($urandom_range(9) < 7) slot = fwd_slot;
    end else if (pick < 87) act = ACT_REQUEST;
    else if (pick < 95) act = ACT_TICK;
    else act = 3'($urandom_range(5, 7));
    send_event(act, slot, 16'($urandom));
  endtask

  initial begin
    int items_per_phase;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    now_us = '0;
    period_now = HB_PERIOD_RST;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: held request, rejection, connect, beats, forward, replies
    send_event(ACT_TICK, 3'd0, 16'h0000);
    send_event(ACT_REQUEST, 3'd0, 16'hFFFF);
    send_event(ACT_REQUEST, 3'd5, 16'h1234);
    send_event(ACT_CONNECT, 3'd0, 16'h0000);
    send_event(ACT_CONNECT, 3'd7, 16'h0000);
    send_event(ACT_CONNECT, 3'd7, 16'h0000);
    send_event(ACT_HBEAT, 3'd3, 16'h0000);
    now_us = 48'd100;
    send_event(ACT_HBEAT, 3'd7, 16'h0000);
    send_event(ACT_HBEAT, 3'd0, 16'h0000);
    send_event(ACT_REPLY, 3'd0, 16'h0000);
    send_event(ACT_REPLY, 3'd7, 16'hAAAA);
    send_event(ACT_REQUEST, 3'd0, 16'h5555);
    send_event(3'd7, 3'd2, 16'h0000);
    send_event(3'd5, 3'd1, 16'h0000);
    now_us = 48'd600000;
    send_event(ACT_TICK, 3'd0, 16'h0000);
    now_us = 48'd2700000;
    send_event(ACT_HBEAT, 3'd0, 16'h0000);
    send_event(ACT_REPLY, 3'd0, 16'h0000);
    send_event(ACT_REPLY, 3'd3, 16'h0000);
    drain();

    // random phases under several register settings and idling patterns
    items_per_phase = 75;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_HB_PERIOD, 24'd1000);  write_reg(CFG_REPLY_TO, 24'd3000);  idle_pct = 0;  end
        1: begin write_reg(CFG_HB_PERIOD, 24'd200);   write_reg(CFG_REPLY_TO, 24'd150);   idle_pct = 68; end
        2: begin write_reg(CFG_HB_PERIOD, 24'd1);     write_reg(CFG_REPLY_TO, 24'hFFFFFF); idle_pct = 0;  end
        3: begin write_reg(CFG_HB_PERIOD, 24'hFFFFFF); write_reg(CFG_REPLY_TO, 24'd1);    idle_pct = 11; end
        4: begin write_reg(CFG_HB_PERIOD, 24'd0);     write_reg(CFG_REPLY_TO, 24'd0);     idle_pct = 68; end
        default: begin
          write_reg(CFG_HB_PERIOD, 24'd5000); write_reg(CFG_REPLY_TO, 24'd12000);
          write_reg(2'd3, 24'h123456);
          idle_pct = 11;
        end
      endcase
      for (int i = 0; i < items_per_phase; i++) begin
        random_event();
        // hold off until everything owed has arrived
        if (ph == 1 && i == 40) drain();
      end
      drain();
    end

    // top of the time range: deadline sums saturate
    write_reg(CFG_HB_PERIOD, 24'hFFFFFF);
    write_reg(CFG_REPLY_TO, 24'hFFFFFF);
    now_us = {TIME_W{1'b1}} - 48'd40000000;
    idle_pct = 0;
    for (int i = 0; i < 20; i++) random_event();
    now_us = {TIME_W{1'b1}};
    send_event(ACT_HBEAT, 3'd0, 16'h0000);
    send_event(ACT_REQUEST, 3'd0, 16'hBEEF);
    send_event(ACT_TICK, 3'd0, 16'h0000);

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/hlfd_pkg.sv
rtl/hlfd_ctrl.sv
rtl/hlfd_datapath.sv
rtl/heartbeat_lru_failover_dispatcher.sv
tb/sv/hlfd_checker.sv
tb/sv/tb_heartbeat_lru_failover_dispatcher.sv
